FILE: rtl/core/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types and constants for the shortest-job-first ordering block.
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int MAX_JOBS_DEFAULT = 32;

    localparam int TIME_W   = 16;
    localparam int NUM_W    = 7;
    localparam int TOTAL_W  = 28;
    // Running sum of up to 64 times of 16 bits.
    localparam int PREFIX_W = 22;

    typedef struct packed {
        logic [TIME_W-1:0] job_time;
        logic              last_job;
    } job_t;

    typedef struct packed {
        logic [NUM_W-1:0]   job_number;
        logic [TIME_W-1:0]  job_length;
        logic [TOTAL_W-1:0] total_completion;
        logic               dropped_jobs;
        logic               final_entry;
    } sched_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // job transaction taken this cycle
        logic sum_step;   // add one sorted entry into the completion total
        logic emit_step;  // load one sorted entry into the output register
        logic end_run;    // clear job count and drop flag
    } sjf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;   // scan index points at the last stored job
        logic out_free;   // output register can take a new entry
    } sjf_status_t;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SUM  = 3'b010,
        ST_EMIT = 3'b100
    } sjf_state_t;

endpackage

FILE: rtl/core/sjf_ctrl.sv
// ----------------------------------------------------------------------------
// sjf_ctrl
// Run controller: loads jobs, then sums completion times, then emits the
// sorted schedule.
// ----------------------------------------------------------------------------
module sjf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  logic                 last_job,
    input  sjf_pkg::sjf_status_t status,
    output sjf_pkg::sjf_cmd_t    cmd,
    output logic                 job_stall
);

    sjf_pkg::sjf_state_t state_reg;
    sjf_pkg::sjf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sjf_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        job_stall     = 1'b1;
        unique case (state_reg)
            sjf_pkg::ST_LOAD:
            begin
                job_stall  = 1'b0;
                cmd.accept = job_valid;
                if (job_valid && last_job)
                begin
                    state_next = sjf_pkg::ST_SUM;
                end
            end
            sjf_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = sjf_pkg::ST_EMIT;
                end
            end
            sjf_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.end_run = 1'b1;
                        state_next  = sjf_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = sjf_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/sjf_datapath.sv
// ----------------------------------------------------------------------------
// sjf_datapath
// Insertion-sort cell chain, completion-time accumulator and output register.
// ----------------------------------------------------------------------------
module sjf_datapath
#(
    parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sjf_pkg::job_t        job,
    input  sjf_pkg::sjf_cmd_t    cmd,
    input  logic                 sched_stall,
    output sjf_pkg::sjf_status_t status,
    output logic                 sched_valid,
    output sjf_pkg::sched_t      sched
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int IDX_W = $clog2(MAX_JOBS);

    logic [sjf_pkg::TIME_W-1:0]   times_reg   [MAX_JOBS];
    logic [sjf_pkg::TIME_W-1:0]   times_next  [MAX_JOBS];
    logic [sjf_pkg::NUM_W-1:0]    numbers_reg [MAX_JOBS];
    logic [sjf_pkg::NUM_W-1:0]    numbers_next[MAX_JOBS];
    logic [MAX_JOBS-1:0]          greater;

    logic [CNT_W-1:0]             count_reg;
    logic                         overflow_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [sjf_pkg::PREFIX_W-1:0] prefix_reg;
    logic [sjf_pkg::PREFIX_W-1:0] prefix_next;
    logic [sjf_pkg::TOTAL_W-1:0]  total_reg;
    logic                         sched_valid_reg;
    sjf_pkg::sched_t              sched_reg;

    logic                         full;
    logic                         insert;
    logic [sjf_pkg::NUM_W-1:0]    new_number;
    logic [sjf_pkg::TIME_W-1:0]   sel_time;

    assign full       = (count_reg == CNT_W'(MAX_JOBS));
    assign insert     = cmd.accept && !full;
    assign new_number = sjf_pkg::NUM_W'(count_reg) + sjf_pkg::NUM_W'(1);

    // Each stored job that is strictly longer than the arrival moves up one
    // cell, so equal times keep their arrival order.
    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            greater[i] = (CNT_W'(i) < count_reg) && (times_reg[i] > job.job_time);
        end
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            times_next[i]   = times_reg[i];
            numbers_next[i] = numbers_reg[i];
            if ((i > 0) && greater[(i > 0) ? i - 1 : 0])
            begin
                times_next[i]   = times_reg[(i > 0) ? i - 1 : 0];
                numbers_next[i] = numbers_reg[(i > 0) ? i - 1 : 0];
            end
            else if (greater[i] || (CNT_W'(i) == count_reg))
            begin
                times_next[i]   = job.job_time;
                numbers_next[i] = new_number;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            times_reg   <= times_next;
            numbers_reg <= numbers_next;
        end
    end

    assign sel_time    = times_reg[idx_reg];
    assign prefix_next = prefix_reg + sjf_pkg::PREFIX_W'(sel_time);

    assign status.idx_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign status.out_free = !sched_valid_reg || !sched_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            idx_reg         <= '0;
            sched_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.end_run)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.accept)
            begin
                overflow_reg <= 1'b1;
            end

            if (cmd.sum_step || cmd.emit_step)
            begin
                idx_reg <= status.idx_last ? '0 : idx_reg + IDX_W'(1);
            end
            else if (cmd.accept)
            begin
                idx_reg <= '0;
            end

            if (cmd.emit_step)
            begin
                sched_valid_reg <= 1'b1;
            end
            else if (!sched_stall)
            begin
                sched_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prefix_reg <= '0;
            total_reg  <= '0;
        end
        else if (cmd.sum_step)
        begin
            prefix_reg <= prefix_next;
            total_reg  <= total_reg + sjf_pkg::TOTAL_W'(prefix_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            sched_reg.job_number       <= numbers_reg[idx_reg];
            sched_reg.job_length       <= sel_time;
            sched_reg.total_completion <= total_reg;
            sched_reg.dropped_jobs     <= overflow_reg;
            sched_reg.final_entry      <= status.idx_last;
        end
    end

    assign sched_valid = sched_valid_reg;
    assign sched       = sched_reg;

endmodule

FILE: rtl/core/shortest_job_first_order_top.sv
// ----------------------------------------------------------------------------
// shortest_job_first_order_top
// Orders jobs by processing time (stable) and emits the schedule with the
// total of completion times when the last job of a run arrives.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake                 | Payload
//   job     | in        | job_valid / job_stall     | sjf_pkg::job_t
//   sched   | out       | sched_valid / sched_stall | sjf_pkg::sched_t
//
// Jobs are taken one per cycle while a run loads; the cell chain places each
// job in the cycle it is accepted. After the last job, the block accumulates
// the completion total over the N stored jobs, then emits the N results in
// sorted order, one per cycle while sched_stall stays low. job_stall is high
// from the last job until the final result has entered the output register.
// Reset clears the job count and drop flag; stored jobs need no clearing.
// ----------------------------------------------------------------------------
module shortest_job_first_order_top
#(
    parameter int MAX_JOBS = sjf_pkg::MAX_JOBS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_stall,
    input  sjf_pkg::job_t   job,
    output logic            sched_valid,
    input  logic            sched_stall,
    output sjf_pkg::sched_t sched
);

    sjf_pkg::sjf_cmd_t    cmd;
    sjf_pkg::sjf_status_t status;

    sjf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .last_job  (job.last_job),
        .status    (status),
        .cmd       (cmd),
        .job_stall (job_stall)
    );

    sjf_datapath
    #(
        .MAX_JOBS (MAX_JOBS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .cmd         (cmd),
        .sched_stall (sched_stall),
        .status      (status),
        .sched_valid (sched_valid),
        .sched       (sched)
    );

endmodule

FILE: rtl/core/sjf_checker.sv
// ----------------------------------------------------------------------------
// sjf_checker
// Port-level checks for the shortest-job-first ordering block.
// ----------------------------------------------------------------------------
module sjf_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            job_valid,
    input logic            job_stall,
    input sjf_pkg::job_t   job,
    input logic            sched_valid,
    input logic            sched_stall,
    input sjf_pkg::sched_t sched
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        sched_valid && sched_stall |=> sched_valid && $stable(sched))
    else $error("stalled result changed");

    // The last job of a run closes the input: job_stall is high right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall && job.last_job |=> job_stall)
    else $error("input open right after the last job");

    // Every result carries a job number from one upward.
    assert property (@(posedge clk) disable iff (!rst_n)
        sched_valid |-> sched.job_number != '0)
    else $error("result with job number zero");

    // Out of reset no result is pending.
    assert property (@(posedge clk)
        $past(!rst_n) |-> !sched_valid)
    else $error("result valid after reset");

endmodule

bind shortest_job_first_order_top sjf_checker u_sjf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job_stall   (job_stall),
    .job         (job),
    .sched_valid (sched_valid),
    .sched_stall (sched_stall),
    .sched       (sched)
);
